@@ rtl/ptom_pkg.sv @@
package ptom_pkg;

  localparam int POOL_DEPTH_MAX = 63;
  localparam int DEF_POOL_DEPTH = 32;
  localparam int PRICE_LEVELS   = 256;
  localparam int ID_BITS        = 16;
  localparam int IDX_W          = 6;
  localparam int AGE_W          = 6;

  localparam logic [15:0] ID_MASK = 16'((64'd1 << ID_BITS) - 64'd1);
  localparam logic [7:0]  PRICE_MAX = 8'((PRICE_LEVELS > 256) ? 255 : PRICE_LEVELS - 1);

  localparam logic FUNC_SUBMIT = 1'b0;
  localparam logic FUNC_CANCEL = 1'b1;
  localparam logic SIDE_BUY    = 1'b0;
  localparam logic SIDE_SELL   = 1'b1;
  localparam logic KIND_MARKET = 1'b0;
  localparam logic KIND_LIMIT  = 1'b1;
  localparam logic ITEM_TRADE  = 1'b0;
  localparam logic ITEM_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_FILLED    = 3'd0,
    ST_RESTED    = 3'd1,
    ST_REMAINDER = 3'd2,
    ST_CANCELLED = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_POOL_FULL = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEED,
    S_WAIT,
    S_EVAL
  } state_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_FILL,
    CMD_INSERT
  } cmd_op_t;

  typedef struct packed {
    logic        func;
    logic [15:0] order_id;
    logic        order_side;
    logic        order_kind;
    logic [7:0]  limit_price;
    logic [31:0] order_qty;
  } order_req_t;

  typedef struct packed {
    logic        item_kind;
    logic [15:0] maker_id;
    logic [7:0]  trade_price;
    logic [31:0] fill_qty;
    logic [2:0]  status_code;
    logic [31:0] left_qty;
    logic        bid_present;
    logic [7:0]  top_bid;
    logic        ask_present;
    logic [7:0]  top_ask;
    logic        last;
  } result_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    cmd_op_t          op;
    logic [IDX_W-1:0] idx;
    logic [31:0]      amt;
    logic             emp;
    logic [AGE_W-1:0] rage;
    logic [15:0]      id;
    logic [7:0]       price;
    logic             side;
    logic [AGE_W-1:0] nage;
  } cmd_t;

  // Sweep packet that travels down the cell chain, one cell per cycle.
  typedef struct packed {
    logic             go;
    logic             opp;
    logic [15:0]      qid;
    logic             hit;
    logic [IDX_W-1:0] bidx;
    logic [7:0]       bprice;
    logic [AGE_W-1:0] bage;
    logic [31:0]      bqty;
    logic [15:0]      bmaker;
    logic             bid_p;
    logic [7:0]       top_bid;
    logic             ask_p;
    logic [7:0]       top_ask;
    logic             id_found;
    logic [IDX_W-1:0] id_idx;
    logic [AGE_W-1:0] id_age;
    logic             free_found;
    logic [IDX_W-1:0] free_idx;
  } sweep_t;

endpackage

@@ rtl/ptom_cell.sv @@
module ptom_cell import ptom_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic   clk,
  input  logic   rst,
  input  cmd_t   cmd,
  input  sweep_t pin,
  output sweep_t pout
);

  localparam logic [IDX_W-1:0] ME = IDX_W'(IDX);

  logic             valid;
  logic [15:0]      id;
  logic [31:0]      qty;
  logic [7:0]       price;
  logic             side;
  logic [AGE_W-1:0] age;

  sweep_t pnext;
  logic   better;

  always_comb begin
    pnext = pin;
    if (pin.opp == SIDE_SELL) begin
      better = !pin.hit || (price < pin.bprice) || (price == pin.bprice && age < pin.bage);
    end else begin
      better = !pin.hit || (price > pin.bprice) || (price == pin.bprice && age < pin.bage);
    end
    if (valid && side == pin.opp && better) begin
      pnext.hit    = 1'b1;
      pnext.bidx   = ME;
      pnext.bprice = price;
      pnext.bage   = age;
      pnext.bqty   = qty;
      pnext.bmaker = id;
    end
    if (valid && side == SIDE_BUY && (!pin.bid_p || price > pin.top_bid)) begin
      pnext.bid_p   = 1'b1;
      pnext.top_bid = price;
    end
    if (valid && side == SIDE_SELL && (!pin.ask_p || price < pin.top_ask)) begin
      pnext.ask_p   = 1'b1;
      pnext.top_ask = price;
    end
    if (!pin.id_found && valid && id == pin.qid) begin
      pnext.id_found = 1'b1;
      pnext.id_idx   = ME;
      pnext.id_age   = age;
    end
    if (!pin.free_found && !valid) begin
      pnext.free_found = 1'b1;
      pnext.free_idx   = ME;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pout <= '0;
    end else begin
      pout <= pnext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (cmd.op)
        CMD_FILL: begin
          if (cmd.idx == ME) begin
            if (cmd.emp) begin
              valid <= 1'b0;
            end else begin
              qty <= qty - cmd.amt;
            end
          end else if (cmd.emp && valid && age > cmd.rage) begin
            // Keep arrival ranks dense so the oldest order has the lowest rank.
            age <= age - 1'b1;
          end
        end
        CMD_INSERT: begin
          if (cmd.idx == ME) begin
            valid <= 1'b1;
            id    <= cmd.id;
            qty   <= cmd.amt;
            price <= cmd.price;
            side  <= cmd.side;
            age   <= cmd.nage;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/price_time_order_matching_core.sv @@
// Limit order book with price-time priority over a pool of POOL_DEPTH resting
// orders, each held in one cell of a chain. A request is taken when start is
// high and busy is low; busy stays high until the status item goes out. Every
// book lookup is a sweep that passes one cell per cycle. A submit needs one
// sweep per fill plus two more, and a cancel needs two. Results appear on res
// for one cycle each, marked by res_valid, with trade items first and the
// status item last; the receiver cannot stall them.
// The configuration channel is always ready and should be written while idle.
module price_time_order_matching_core import ptom_pkg::*; #(
  parameter int POOL_DEPTH = DEF_POOL_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  order_req_t req,
  output logic       res_valid,
  output result_t    res,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data
);

  state_t state, state_next;

  logic             trade_en;
  logic             final_r, final_next;
  logic             func;
  logic [15:0]      qid;
  logic             side;
  logic             kind;
  logic [7:0]       price;
  logic [31:0]      left, left_next;
  status_t          status, status_next;
  logic [AGE_W-1:0] count, count_next;
  sweep_t           sw;
  cmd_t             cmd;
  result_t          res_next;
  logic             res_valid_next;

  sweep_t pin  [POOL_DEPTH];
  sweep_t pout [POOL_DEPTH];
  sweep_t seed;

  logic        price_ok;
  logic        can_fill;
  logic [31:0] fill;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    seed      = '0;
    seed.go   = (state == S_SEED);
    seed.opp  = ~side;
    seed.qid  = qid;
  end

  for (genvar k = 0; k < POOL_DEPTH; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign pin[k] = seed;
    end else begin : g_link
      assign pin[k] = pout[k-1];
    end
    ptom_cell #(.IDX(k)) u_cell (
      .clk  (clk),
      .rst  (rst),
      .cmd  (cmd),
      .pin  (pin[k]),
      .pout (pout[k])
    );
  end

  always_comb begin
    if (kind == KIND_MARKET) begin
      price_ok = 1'b1;
    end else if (side == SIDE_BUY) begin
      price_ok = (sw.bprice <= price);
    end else begin
      price_ok = (sw.bprice >= price);
    end
    can_fill = (left != 32'd0) && sw.hit && price_ok;
    fill     = (left < sw.bqty) ? left : sw.bqty;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = S_SEED;
      S_SEED: state_next = S_WAIT;
      S_WAIT: if (pout[POOL_DEPTH-1].go) state_next = S_EVAL;
      S_EVAL: state_next = final_r ? S_IDLE : S_SEED;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.op         = CMD_NONE;
    final_next     = final_r;
    left_next      = left;
    status_next    = status;
    count_next     = count;
    res_next       = res;
    res_valid_next = 1'b0;
    if (state == S_IDLE) begin
      final_next = 1'b0;
      left_next  = req.order_qty;
    end else if (state == S_EVAL) begin
      if (final_r) begin
        res_next             = '0;
        res_next.item_kind   = ITEM_STATUS;
        res_next.status_code = status;
        res_next.left_qty    = (func == FUNC_CANCEL) ? 32'd0 : left;
        res_next.bid_present = sw.bid_p;
        res_next.top_bid     = sw.bid_p ? sw.top_bid : 8'd0;
        res_next.ask_present = sw.ask_p;
        res_next.top_ask     = sw.ask_p ? sw.top_ask : 8'd0;
        res_next.last        = 1'b1;
        res_valid_next       = 1'b1;
      end else if (func == FUNC_CANCEL) begin
        final_next = 1'b1;
        if (sw.id_found) begin
          cmd.op      = CMD_FILL;
          cmd.idx     = sw.id_idx;
          cmd.emp     = 1'b1;
          cmd.rage    = sw.id_age;
          count_next  = count - 1'b1;
          status_next = ST_CANCELLED;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end else if (can_fill) begin
        cmd.op    = CMD_FILL;
        cmd.idx   = sw.bidx;
        cmd.amt   = fill;
        cmd.emp   = (fill == sw.bqty);
        cmd.rage  = sw.bage;
        left_next = left - fill;
        if (fill == sw.bqty) begin
          count_next = count - 1'b1;
        end
        if (trade_en) begin
          res_next             = '0;
          res_next.item_kind   = ITEM_TRADE;
          res_next.maker_id    = sw.bmaker;
          res_next.trade_price = sw.bprice;
          res_next.fill_qty    = fill;
          res_valid_next       = 1'b1;
        end
      end else begin
        final_next = 1'b1;
        if (left == 32'd0) begin
          status_next = ST_FILLED;
        end else if (kind == KIND_MARKET) begin
          status_next = ST_REMAINDER;
        end else if (sw.free_found) begin
          cmd.op      = CMD_INSERT;
          cmd.idx     = sw.free_idx;
          cmd.amt     = left;
          cmd.id      = qid;
          cmd.price   = price;
          cmd.side    = side;
          cmd.nage    = count;
          count_next  = count + 1'b1;
          status_next = ST_RESTED;
        end else begin
          status_next = ST_POOL_FULL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      final_r   <= 1'b0;
      count     <= '0;
      trade_en  <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      final_r   <= final_next;
      count     <= count_next;
      res_valid <= res_valid_next;
      if (cfg_valid && cfg_ready) begin
        trade_en <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    left   <= left_next;
    status <= status_next;
    res    <= res_next;
    if (state == S_IDLE && start) begin
      func  <= req.func;
      qid   <= req.order_id & ID_MASK;
      side  <= req.order_side;
      kind  <= req.order_kind;
      price <= (int'(req.limit_price) >= PRICE_LEVELS) ? PRICE_MAX : req.limit_price;
    end
    if (state == S_WAIT && pout[POOL_DEPTH-1].go) begin
      sw <= pout[POOL_DEPTH-1];
    end
  end

endmodule

@@ verif/price_time_order_matching_core_tb.sv @@
`timescale 1ns / 100ps

module price_time_order_matching_core_tb;
  import ptom_pkg::*;

  localparam int NPOOL = DEF_POOL_DEPTH;
  localparam int WATCH_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 1300;
  localparam int CFG_HOLD = 40;

  typedef struct {
    bit         is_cfg;
    bit         cfg_val;
    order_req_t r;
  } book_op_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  order_req_t req;
  logic       res_valid;
  result_t    res;
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  price_time_order_matching_core uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .res_valid(res_valid), .res(res), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Shadow book.
  logic [15:0]  bk_id    [NPOOL];
  logic [31:0]  bk_qty   [NPOOL];
  logic [7:0]   bk_price [NPOOL];
  logic         bk_side  [NPOOL];
  bit           bk_valid [NPOOL];
  int unsigned  bk_seq   [NPOOL];
  int unsigned  seq_ctr;
  bit           report_en;

  book_op_t     pending_ops[$];
  result_t      expected_items[$];
  int           err_cnt;
  bit           quiet;
  bit           req_taken, cfg_taken;
  int           watch_cnt;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Best resting entry on one side: price first, then age.
  function automatic int best_entry(logic side);
    int b;
    b = -1;
    for (int e = 0; e < NPOOL; e++) begin
      if (bk_valid[e] && bk_side[e] == side) begin
        if (b < 0) b = e;
        else if (bk_price[e] != bk_price[b]) begin
          if ((side == SIDE_BUY) ? (bk_price[e] > bk_price[b]) : (bk_price[e] < bk_price[b]))
            b = e;
        end else if (bk_seq[e] < bk_seq[b]) b = e;
      end
    end
    return b;
  endfunction

  function automatic result_t status_item(logic [2:0] code, logic [31:0] left);
    result_t s;
    int bb, ba;
    s = '0;
    bb = best_entry(SIDE_BUY);
    ba = best_entry(SIDE_SELL);
    s.item_kind = ITEM_STATUS;
    s.status_code = code;
    s.left_qty = left;
    s.bid_present = (bb >= 0);
    s.top_bid = (bb >= 0) ? bk_price[bb] : 8'd0;
    s.ask_present = (ba >= 0);
    s.top_ask = (ba >= 0) ? bk_price[ba] : 8'd0;
    s.last = 1'b1;
    return s;
  endfunction

  task automatic match_order(order_req_t r);
    logic [31:0] left, fill;
    logic [2:0]  code;
    logic        opp;
    int          h, n, fr;
    result_t     t;
    left = r.order_qty;
    opp = ~r.order_side;
    n = 0;
    if (r.func == FUNC_CANCEL) begin
      code = ST_NOT_FOUND;
      for (int e = 0; e < NPOOL; e++) begin
        if (bk_valid[e] && bk_id[e] == r.order_id) begin
          bk_valid[e] = 1'b0;
          code = ST_CANCELLED;
          break;
        end
      end
      expected_items = {expected_items, status_item(code, 32'd0)};
      return;
    end
    while (left != 32'd0) begin
      h = best_entry(opp);
      if (h < 0) break;
      if (r.order_kind == KIND_LIMIT) begin
        if (r.order_side == SIDE_BUY && bk_price[h] > r.limit_price) break;
        if (r.order_side == SIDE_SELL && bk_price[h] < r.limit_price) break;
      end
      fill = (left < bk_qty[h]) ? left : bk_qty[h];
      left -= fill;
      bk_qty[h] -= fill;
      if (report_en && n < 63) begin
        t = '0;
        t.item_kind = ITEM_TRADE;
        t.maker_id = bk_id[h];
        t.trade_price = bk_price[h];
        t.fill_qty = fill;
        expected_items = {expected_items, t};
        n++;
      end
      if (bk_qty[h] == 32'd0) bk_valid[h] = 1'b0;
    end
    if (left == 32'd0) code = ST_FILLED;
    else if (r.order_kind == KIND_MARKET) code = ST_REMAINDER;
    else begin
      code = ST_POOL_FULL;
      fr = -1;
      for (int e = 0; e < NPOOL; e++) begin
        if (!bk_valid[e]) begin
          fr = e;
          break;
        end
      end
      if (fr >= 0) begin
        bk_valid[fr] = 1'b1;
        bk_id[fr] = r.order_id;
        bk_qty[fr] = left;
        bk_price[fr] = r.limit_price;
        bk_side[fr] = r.order_side;
        bk_seq[fr] = seq_ctr++;
        code = ST_RESTED;
      end
    end
    expected_items = {expected_items, status_item(code, left)};
  endtask

  // Monitor and predictor.
  always @(posedge clk) begin
    result_t ex;
    req_taken = 1'b0;
    cfg_taken = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        req_taken = 1'b1;
        match_order(req);
      end
      if (cfg_valid && cfg_ready) begin
        cfg_taken = 1'b1;
        report_en = cfg_data;
      end
      if (res_valid) begin
        if (expected_items.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result item %h", res);
        end else begin
          ex = expected_items.pop_front();
          if (res.item_kind !== ex.item_kind || res.maker_id !== ex.maker_id ||
              res.trade_price !== ex.trade_price || res.fill_qty !== ex.fill_qty ||
              res.status_code !== ex.status_code || res.left_qty !== ex.left_qty ||
              res.bid_present !== ex.bid_present || res.top_bid !== ex.top_bid ||
              res.ask_present !== ex.ask_present || res.top_ask !== ex.top_ask ||
              res.last !== ex.last) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected %h actual %h", ex, res);
          end
        end
      end
      if (req_taken || cfg_taken || res_valid) watch_cnt = 0;
      else watch_cnt++;
      if (watch_cnt >= WATCH_LIMIT) begin
        $display("** price_time_order_matching_core: FAILED **");
        $finish;
      end
    end
  end

  // Driver.
  bit       sending, cfg_wait;
  bit       nxt_cfg_val;
  int       idle_cnt, hold_cnt;
  book_op_t cur;
  always @(negedge clk) begin
    logic nxt_start, nxt_cfg;
    nxt_start = start;
    nxt_cfg = cfg_valid;
    if (!rst) begin
      if (sending && req_taken) begin
        sending = 1'b0;
        nxt_start = 1'b0;
        if (!quiet && $urandom_range(0, 3) == 0) idle_cnt = $urandom_range(1, 10);
      end
      if (cfg_valid && cfg_taken) nxt_cfg = 1'b0;
      if (cfg_wait) begin
        if (expected_items.size() == 0 && !busy && !sending) begin
          hold_cnt++;
          if (hold_cnt >= CFG_HOLD) begin
            nxt_cfg = 1'b1;
            cfg_data <= cur.cfg_val;
            cfg_wait = 1'b0;
          end
        end else hold_cnt = 0;
      end else if (idle_cnt > 0) begin
        idle_cnt--;
      end else if (!sending && !nxt_cfg && pending_ops.size() > 0) begin
        cur = pending_ops.pop_front();
        if (cur.is_cfg) begin
          cfg_wait = 1'b1;
          hold_cnt = 0;
        end else begin
          req <= cur.r;
          nxt_start = 1'b1;
          sending = 1'b1;
        end
      end
    end
    start <= nxt_start;
    cfg_valid <= nxt_cfg;
  end

  task automatic add_req(logic f, logic [15:0] id, logic sd, logic kd, logic [7:0] p,
                         logic [31:0] q);
    book_op_t o;
    o.is_cfg = 1'b0;
    o.cfg_val = 1'b0;
    o.r = '{func: f, order_id: id, order_side: sd, order_kind: kd, limit_price: p,
            order_qty: q};
    pending_ops = {pending_ops, o};
  endtask

  task automatic add_cfg(bit v);
    book_op_t o;
    o.is_cfg = 1'b1;
    o.cfg_val = v;
    o.r = '0;
    pending_ops = {pending_ops, o};
  endtask

  task automatic add_random(bit rest_bias);
    logic [15:0] id;
    logic [31:0] q;
    logic        sd;
    logic [7:0]  p;
    id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40));
    case ($urandom_range(0, 9))
      0: q = 32'($urandom);
      1: q = 32'hFFFF_FFFF;
      2: q = 32'd0;
      default: q = $urandom_range(1, 60);
    endcase
    sd = 1'($urandom_range(0, 1));
    if (rest_bias) p = (sd == SIDE_BUY) ? 8'($urandom_range(0, 120)) : 8'($urandom_range(130, 255));
    else if ($urandom_range(0, 7) == 0) p = 8'($urandom);
    else p = 8'($urandom_range(110, 140));
    if ($urandom_range(0, 3) == 0) add_req(FUNC_CANCEL, id, sd, 1'($urandom_range(0, 1)), p, q);
    else add_req(FUNC_SUBMIT, id, sd, ($urandom_range(0, 4) != 0) ? KIND_LIMIT : KIND_MARKET,
                 p, q);
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    err_cnt = 0;
    quiet = 1'b0;
    seq_ctr = 0;
    report_en = 1'b0;
    watch_cnt = 0;
    idle_cnt = 0;
    for (int e = 0; e < NPOOL; e++) bk_valid[e] = 1'b0;

    // Directed part: empty book, zero quantity, extreme prices and sizes, crossing
    // orders, time priority, duplicate ids and cancels.
    add_req(FUNC_SUBMIT, 16'd1, SIDE_BUY, KIND_MARKET, 8'd0, 32'd5);
    add_cfg(1'b1);
    add_req(FUNC_SUBMIT, 16'd2, SIDE_SELL, KIND_LIMIT, 8'd10, 32'd0);
    add_req(FUNC_SUBMIT, 16'hFFFF, SIDE_SELL, KIND_LIMIT, 8'd255, 32'hFFFF_FFFF);
    add_req(FUNC_SUBMIT, 16'd3, SIDE_BUY, KIND_LIMIT, 8'd0, 32'd7);
    add_req(FUNC_SUBMIT, 16'd4, SIDE_SELL, KIND_LIMIT, 8'd100, 32'd10);
    add_req(FUNC_SUBMIT, 16'd5, SIDE_SELL, KIND_LIMIT, 8'd100, 32'd20);
    add_req(FUNC_SUBMIT, 16'd5, SIDE_SELL, KIND_LIMIT, 8'd90, 32'd3);
    add_req(FUNC_SUBMIT, 16'd6, SIDE_BUY, KIND_LIMIT, 8'd100, 32'd18);
    add_req(FUNC_SUBMIT, 16'd7, SIDE_BUY, KIND_MARKET, 8'd0, 32'd100);
    add_req(FUNC_SUBMIT, 16'd8, SIDE_SELL, KIND_MARKET, 8'd255, 32'd2);
    add_req(FUNC_SUBMIT, 16'd9, SIDE_SELL, KIND_LIMIT, 8'd0, 32'd10);
    add_req(FUNC_CANCEL, 16'hFFFF, SIDE_BUY, KIND_MARKET, 8'd0, 32'd0);
    add_req(FUNC_CANCEL, 16'hFFFF, SIDE_SELL, KIND_LIMIT, 8'd255, 32'hFFFF_FFFF);
    add_req(FUNC_SUBMIT, 16'd10, SIDE_BUY, KIND_LIMIT, 8'd255, 32'd1);
    add_req(FUNC_SUBMIT, 16'd10, SIDE_BUY, KIND_LIMIT, 8'd255, 32'd1);
    add_req(FUNC_CANCEL, 16'd10, SIDE_BUY, KIND_LIMIT, 8'd0, 32'd0);
    add_req(FUNC_SUBMIT, 16'd11, SIDE_SELL, KIND_MARKET, 8'd0, 32'hFFFF_FFFF);

    // Random phases; resting-biased phases fill the pool so full-pool rejects occur.
    for (int ph = 0; ph < 4; ph++) begin
      add_cfg(ph[0]);
      for (int i = 0; i < 100; i++) add_random((ph == 1 || ph == 3) && i < 45);
    end
    add_cfg(1'b1);
    for (int i = 0; i < 20; i++) add_random(1'b0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    wait (pending_ops.size() < 30);
    quiet = 1'b1;
    wait (pending_ops.size() == 0 && !sending && !cfg_wait && !cfg_valid);
    wait (expected_items.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_cnt == 0 && expected_items.size() == 0) begin
      $display("** price_time_order_matching_core: PASSED **");
    end else begin
      $display("** price_time_order_matching_core: FAILED **");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ptom_pkg.sv
rtl/ptom_cell.sv
rtl/price_time_order_matching_core.sv
verif/price_time_order_matching_core_tb.sv
